// ===== hdl/pee_pkg.sv =====
// Package for the postfix expression evaluator.
// Holds character codes, status codes, the controller state type and the
// command and status bundles shared by the controller and the datapath.
package pee_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_SHORT    = 2'd1;
   localparam logic [1:0] STAT_DIVZERO  = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   localparam int OUT_VALUE_BITS = 32;
   localparam int RSP_DATA_BITS  = 40;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD,
      S_ARITH,
      S_FINISH
   } ctrl_state_type;

   typedef enum logic [1:0] {
      ALU_ADDSUB,
      ALU_MUL,
      ALU_DIV
   } alu_mode_type;

   typedef struct packed {
      logic capture;
      logic push;
      logic shortage;
      logic read_a;
      logic start_op;
      logic step;
      logic commit;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_digit;
      logic is_op;
      logic enough;
      logic alu_done;
      logic last_item;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hdl/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator.
// Joins pee_ctrl and pee_datapath; depends on pee_pkg.
//
// The req_ channel carries one ASCII character per transfer, with req_tlast
// marking the last character of an expression. Digits push their value, the
// operators + - * / combine the two top operands, and all other characters
// are ignored. After the last character one result leaves on the rsp_
// channel: the expression value and a status code (ok, operand shortage,
// divide by zero, stack overflow). The value reads zero whenever the status
// is not ok.
// One character is in work at a time. A digit or an ignored character passes
// through the EXEC and FINISH states; an operator with two operands also passes
// LOAD and ARITH, where * and / use the shared shift-and-add multiplier and
// restoring divider, which retire one bit a cycle. A division by zero skips the
// divider.
// The result is loaded into the rsp_ register at the same edge that raises
// req_tready again. A new character is taken while that result waits; if the
// receiver stalls, the next expression's result waits in the last cycle of
// its final character until the register is free.
// Reset empties the stack, clears the status and drops any pending result.
module postfix_expression_evaluator import pee_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] symbol
   input  logic                     req_tlast,   // end_of_expression
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // [31:0] value, [33:32] status, zero above
);

   dp_cmd_type                cmd;
   dp_status_type             stat;
   logic [OUT_VALUE_BITS-1:0] rsp_value;
   logic [1:0]                rsp_status;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_symbol (req_tdata),
      .req_last   (req_tlast),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {(RSP_DATA_BITS - OUT_VALUE_BITS - 2)'(0), rsp_status, rsp_value};

   // A character is worked on alone, so ready drops after every transfer.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Input taken again right after a transfer.");

   // Any error status carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33:32] != STAT_OK) |-> rsp_tdata[31:0] == '0)
      else $error("Nonzero value reported with an error status.");

   // A new result is loaded only while the input side is busy finishing.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("Result appeared without a finished character.");

endmodule

// ===== hdl/pee_ctrl.sv =====
// Controller state machine of the postfix expression evaluator.
// Sequences each character through decode, operand read, arithmetic and result.
// Depends on pee_pkg for the state type and the command and status bundles.
module pee_ctrl import pee_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.is_op && stat.enough) state_in = S_LOAD;
            else state_in = S_FINISH;
         end
         S_LOAD: begin
            state_in = S_ARITH;
         end
         S_ARITH: begin
            if (stat.alu_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.last_item || stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            cmd.push     = stat.is_digit;
            cmd.shortage = stat.is_op && !stat.enough;
            cmd.read_a   = stat.is_op && stat.enough;
         end
         S_LOAD: begin
            cmd.start_op = 1'b1;
         end
         S_ARITH: begin
            cmd.commit = stat.alu_done;
            cmd.step   = !stat.alu_done;
         end
         S_FINISH: begin
            cmd.emit = stat.last_item && stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/pee_datapath.sv =====
// Datapath of the postfix expression evaluator: operand stack memory with the
// top entry in a register, an iterative multiply and divide unit, error status
// and the result register. Depends on pee_pkg.
module pee_datapath import pee_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_symbol,
   input  logic                      req_last,
   input  dp_cmd_type                cmd,
   output dp_status_type             stat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [OUT_VALUE_BITS-1:0] rsp_value,
   output logic [1:0]                rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int IW = $clog2(VALUE_BITS + 1);
   localparam logic [CW-1:0] DEPTH_COUNT = CW'(STACK_DEPTH);
   localparam logic [IW-1:0] STEPS       = IW'(VALUE_BITS);

   logic [VALUE_BITS-1:0] stack_mem [STACK_DEPTH];

   logic [7:0]                sym_ff, sym_in;
   logic                      last_ff, last_in;
   logic [VALUE_BITS-1:0]     tos_ff, tos_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [VALUE_BITS-1:0]     lastres_ff, lastres_in;
   logic [1:0]                err_ff, err_in;
   logic [VALUE_BITS-1:0]     rdata_ff;
   logic [VALUE_BITS-1:0]     acc_ff, acc_in;
   logic [VALUE_BITS-1:0]     x_ff, x_in;
   logic [VALUE_BITS-1:0]     y_ff, y_in;
   logic [IW-1:0]             iter_ff, iter_in;
   alu_mode_type              mode_ff, mode_in;
   logic                      neg_ff, neg_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   logic                         full;
   logic                         mem_we;
   logic [CW-1:0]                cnt_m1;
   logic [CW-1:0]                cnt_m2;
   logic [7:0]                   digit_code;
   logic [VALUE_BITS-1:0]        a_mag;
   logic [VALUE_BITS-1:0]        b_mag;
   logic                         a_neg;
   logic                         b_neg;
   logic [VALUE_BITS:0]          trial;
   logic [VALUE_BITS-1:0]        alu_result;
   logic signed [VALUE_BITS-1:0] sel_value;
   logic signed [63:0]           wide_value;

   assign cnt_m1     = count_ff - CW'(1);
   assign cnt_m2     = count_ff - CW'(2);
   assign full       = count_ff >= DEPTH_COUNT;
   assign mem_we     = cmd.push && !full && (count_ff != '0);
   assign digit_code = sym_ff - CHAR_ZERO;
   assign a_neg      = rdata_ff[VALUE_BITS-1];
   assign b_neg      = tos_ff[VALUE_BITS-1];
   assign a_mag      = a_neg ? (VALUE_BITS'(0) - rdata_ff) : rdata_ff;
   assign b_mag      = b_neg ? (VALUE_BITS'(0) - tos_ff) : tos_ff;
   assign trial      = {acc_ff, x_ff[VALUE_BITS-1]} - {1'b0, y_ff};
   assign alu_result = (mode_ff == ALU_DIV) ? (neg_ff ? (VALUE_BITS'(0) - x_ff) : x_ff) : acc_ff;

   always_comb begin
      if (err_ff != STAT_OK) sel_value = '0;
      else if (count_ff == CW'(1)) sel_value = tos_ff;
      else sel_value = lastres_ff;
   end
   assign wide_value = 64'(sel_value);

   always_comb begin
      stat.is_digit  = (err_ff != STAT_SHORT) && (sym_ff inside {[CHAR_ZERO:CHAR_NINE]});
      stat.is_op     = (err_ff != STAT_SHORT) &&
                       (sym_ff inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH});
      stat.enough    = count_ff >= CW'(2);
      stat.alu_done  = iter_ff == '0;
      stat.last_item = last_ff;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[cnt_m1[AW-1:0]] <= tos_ff;
      if (cmd.read_a) rdata_ff <= stack_mem[cnt_m2[AW-1:0]];
   end

   always_comb begin
      sym_in        = sym_ff;
      last_in       = last_ff;
      tos_in        = tos_ff;
      count_in      = count_ff;
      lastres_in    = lastres_ff;
      err_in        = err_ff;
      acc_in        = acc_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      iter_in       = iter_ff;
      mode_in       = mode_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.capture) begin
         sym_in  = req_symbol;
         last_in = req_last;
      end

      if (cmd.push) begin
         if (full) begin
            if (err_ff == STAT_OK) err_in = STAT_OVERFLOW;
         end else begin
            tos_in   = VALUE_BITS'(digit_code);
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.shortage) err_in = STAT_SHORT;

      if (cmd.start_op) begin
         neg_in = 1'b0;
         case (sym_ff)
            CHAR_PLUS: begin
               mode_in = ALU_ADDSUB;
               acc_in  = rdata_ff + tos_ff;
               iter_in = '0;
            end
            CHAR_MINUS: begin
               mode_in = ALU_ADDSUB;
               acc_in  = rdata_ff - tos_ff;
               iter_in = '0;
            end
            CHAR_STAR: begin
               mode_in = ALU_MUL;
               acc_in  = '0;
               x_in    = rdata_ff;
               y_in    = tos_ff;
               iter_in = STEPS;
            end
            default: begin
               mode_in = ALU_DIV;
               acc_in  = '0;
               y_in    = b_mag;
               if (tos_ff == '0) begin
                  x_in    = '0;
                  iter_in = '0;
                  if (err_ff == STAT_OK) err_in = STAT_DIVZERO;
               end else begin
                  x_in    = a_mag;
                  iter_in = STEPS;
                  neg_in  = a_neg ^ b_neg;
               end
            end
         endcase
      end

      if (cmd.step) begin
         iter_in = iter_ff - IW'(1);
         if (mode_ff == ALU_MUL) begin
            acc_in = acc_ff + (y_ff[0] ? x_ff : '0);
            x_in   = x_ff << 1;
            y_in   = y_ff >> 1;
         end else if (!trial[VALUE_BITS]) begin
            acc_in = trial[VALUE_BITS-1:0];
            x_in   = {x_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            acc_in = {acc_ff[VALUE_BITS-2:0], x_ff[VALUE_BITS-1]};
            x_in   = {x_ff[VALUE_BITS-2:0], 1'b0};
         end
      end

      if (cmd.commit) begin
         tos_in     = alu_result;
         lastres_in = alu_result;
         count_in   = cnt_m1;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = wide_value[OUT_VALUE_BITS-1:0];
         rsp_status_in = err_ff;
         count_in      = '0;
         lastres_in    = '0;
         err_in        = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lastres_ff   <= '0;
         err_ff       <= STAT_OK;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lastres_ff   <= lastres_in;
         err_ff       <= err_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      last_ff       <= last_in;
      tos_ff        <= tos_in;
      acc_ff        <= acc_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      mode_ff       <= mode_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
